### design/etpd_pkg.sv
// Package for the error text pattern disabler: phrase table, sizes and the
// structs passed between the top level and the match cells. No dependencies.
`default_nettype none

package etpd_pkg;

  // Slots of the phrase table and the longest phrase a slot can hold.
  localparam int PHRASE_SLOTS     = 32;
  localparam int PHRASE_MAX_CHARS = 64;
  localparam int PHRASE_BITS      = PHRASE_MAX_CHARS * 8;

  // Defaults of the top level parameters.
  localparam int DEF_NUM_PHRASES    = 11;
  localparam int DEF_MAX_PHRASE_LEN = 28;

  // Wide enough for any phrase number and for a "none" code up to PHRASE_SLOTS.
  localparam int PHRASE_IDX_W = $clog2(PHRASE_SLOTS + 1);

  // Width of the reported phrase number.
  localparam int PATTERN_IDX_W = 4;

  // Operation codes of an input item.
  localparam logic OP_TEXT    = 1'b0;
  localparam logic OP_DISABLE = 1'b1;

  // Per-byte control broadcast to every cell.
  typedef struct packed {
    logic       step;       // a text byte is transferred this cycle
    logic       clear;      // it is the last byte of the message
    logic [7:0] text_byte;
  } etpd_scan_t;

  // Lowest-found search carried along the row of cells.
  typedef struct packed {
    logic                    hit;
    logic [PHRASE_IDX_W-1:0] idx;
  } etpd_chain_t;

  // Phrase text, right aligned: the first character sits in the highest
  // used byte, the last character in bits [7:0]. The escape \137 is the
  // underscore character.
  function automatic logic [PHRASE_BITS-1:0] phrase_text(input int slot);
    logic [PHRASE_BITS-1:0] t;
    t = '0;
    unique case (slot)
      0:       t = "text only";
      1:       t = "text-only";
      2:       t = "does not support image";
      3:       t = "image input is not supported";
      4:       t = "does not support vision";
      5:       t = "vision is not supported";
      6:       t = "content has invalid image";
      7:       t = "images are not supported";
      8:       t = "image\137url is not supported";
      9:       t = "image\137url is not enabled";
      10:      t = "image data is not supported";
      default: t = '0;
    endcase
    return t;
  endfunction

  // Phrase length in characters; zero for an empty slot.
  function automatic int phrase_len(input int slot);
    int n;
    n = 0;
    unique case (slot)
      0:       n = 9;
      1:       n = 9;
      2:       n = 22;
      3:       n = 28;
      4:       n = 23;
      5:       n = 23;
      6:       n = 25;
      7:       n = 24;
      8:       n = 26;
      9:       n = 24;
      10:      n = 27;
      default: n = 0;
    endcase
    return n;
  endfunction

endpackage : etpd_pkg

`default_nettype wire

### design/etpd_in_if.sv
// Input channel of the error text pattern disabler: valid/ready handshake
// with op, text byte and last-byte mark. Depends on nothing.
`default_nettype none

interface etpd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] text_byte;
  logic       last;

  modport source (output valid, output op, output text_byte, output last, input ready);
  modport sink   (input valid, input op, input text_byte, input last, output ready);
endinterface : etpd_in_if

`default_nettype wire

### design/etpd_out_if.sv
// Result channel of the error text pattern disabler: valid/ready handshake
// with the disable report. Depends on nothing.
`default_nettype none

interface etpd_out_if;
  logic       valid;
  logic       ready;
  logic       newly_disabled;
  logic       disabled;
  logic [3:0] pattern_index;

  modport source (output valid, output newly_disabled, output disabled,
                  output pattern_index, input ready);
  modport sink   (input valid, input newly_disabled, input disabled,
                  input pattern_index, output ready);
endinterface : etpd_out_if

`default_nettype wire

### design/etpd_cell.sv
// One match cell: shift-and progress vector and found bit for one phrase,
// plus one link of the lowest-found chain. Depends on etpd_pkg.
`default_nettype none

module etpd_cell
  import etpd_pkg::*;
#(
  parameter int PHRASE_ID      = 0,
  parameter int MAX_PHRASE_LEN = DEF_MAX_PHRASE_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire etpd_scan_t  scan,
  input  wire etpd_chain_t chain_i,
  output etpd_chain_t      chain_o
);

  localparam logic [PHRASE_BITS-1:0] TEXT = phrase_text(PHRASE_ID);
  localparam int  LEN    = phrase_len(PHRASE_ID);
  // A phrase that does not fit the vector never matches.
  localparam bit  ACTIVE = (LEN > 0) && (LEN <= MAX_PHRASE_LEN);
  localparam int  TOP    = ACTIVE ? LEN - 1 : 0;

  logic [MAX_PHRASE_LEN-1:0] vec_r, vec_nxt;
  logic [MAX_PHRASE_LEN-1:0] hits;
  logic [MAX_PHRASE_LEN-1:0] vec_sh;
  logic [MAX_PHRASE_LEN-1:0] vec_upd;
  logic                      found_r, found_nxt;
  logic                      found_upd;

  // Positions of the phrase that hold the incoming character.
  always_comb begin
    hits = '0;
    for (int j = 0; j < MAX_PHRASE_LEN; j++) begin
      if (ACTIVE && (j < LEN)) begin
        hits[j] = (TEXT[(LEN - 1 - j) * 8 +: 8] == scan.text_byte);
      end
    end
  end

  always_comb begin
    vec_sh    = vec_r << 1;
    vec_upd   = (vec_sh | MAX_PHRASE_LEN'(1)) & hits;
    found_upd = found_r | (ACTIVE && vec_upd[TOP]);
  end

  always_comb begin
    vec_nxt   = vec_r;
    found_nxt = found_r;
    if (scan.step) begin
      if (scan.clear) begin
        vec_nxt   = '0;
        found_nxt = 1'b0;
      end else begin
        vec_nxt   = vec_upd;
        found_nxt = found_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r   <= '0;
      found_r <= 1'b0;
    end else begin
      vec_r   <= vec_nxt;
      found_r <= found_nxt;
    end
  end

  // A lower-numbered hit upstream wins; otherwise this cell claims the slot.
  always_comb begin
    chain_o = chain_i;
    if (!chain_i.hit && found_upd) begin
      chain_o.hit = 1'b1;
      chain_o.idx = PHRASE_IDX_W'(PHRASE_ID);
    end
  end

endmodule : etpd_cell

`default_nettype wire

### design/error_text_pattern_disabler_core.sv
// Top level of the error text pattern disabler: a row of match cells, the
// sticky disabled flag and the output register. Depends on etpd_pkg,
// etpd_in_if, etpd_out_if and etpd_cell.
`default_nettype none

// The block scans an error message one byte per transfer, with the last
// byte marked, and looks case-sensitively and at any position for a fixed
// list of phrases (the table in etpd_pkg). Each phrase has its own cell in
// a row; every cell keeps a shift-and progress vector and a found bit, and
// the cells hand a lowest-found phrase number down the row. Message bytes
// produce no result except the last one, which produces a report: whether
// this message newly set the sticky disabled flag, the flag itself, and the
// lowest matched phrase number (NUM_PHRASES means none). When the flag was
// already set, a message still gets a report, but with newly_disabled low
// and no phrase number. An item with op high sets the flag at once, leaves
// any message in progress untouched, and reports the flag. The block takes
// one item per clock cycle unless input stalls; all cells update at once
// and the priority chain runs through them, which allows that rate. A
// report appears on the result channel in the cycle after the transfer
// that caused it and is held in an output register; input flows while
// it is free or drained and stalls only while it is full and not drained.
// After reset the flag is clear and no search state is pending.
module error_text_pattern_disabler_core
  import etpd_pkg::*;
#(
  parameter int NUM_PHRASES    = DEF_NUM_PHRASES,
  parameter int MAX_PHRASE_LEN = DEF_MAX_PHRASE_LEN
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  etpd_in_if.sink    in_chan,
  etpd_out_if.source out_chan
);

  localparam logic [PHRASE_IDX_W-1:0] IDX_NONE = PHRASE_IDX_W'(NUM_PHRASES);

  // Handshake on the input side.
  logic       in_xfer;
  logic       text_xfer;
  logic       emit;
  etpd_scan_t scan;

  // Chain through the cells; link 0 enters with no hit.
  etpd_chain_t chain [NUM_PHRASES + 1];

  // Sticky flag and output register.
  logic                     disabled_r, disabled_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     newly_r, newly_nxt;
  logic                     flag_out_r, flag_out_nxt;
  logic [PATTERN_IDX_W-1:0] index_r, index_nxt;
  logic [PHRASE_IDX_W-1:0]  idx_sel;

  // Input is taken whenever the output register is free or being drained.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign text_xfer     = in_xfer && (in_chan.op == OP_TEXT);
  // A report follows a force-disable item or the last byte of a message.
  assign emit          = in_xfer && ((in_chan.op == OP_DISABLE) || in_chan.last);

  assign scan.step      = text_xfer;
  assign scan.clear     = in_chan.last;
  assign scan.text_byte = in_chan.text_byte;

  assign chain[0].hit = 1'b0;
  assign chain[0].idx = IDX_NONE;

  for (genvar i = 0; i < NUM_PHRASES; i++) begin : g_cell
    etpd_cell #(
      .PHRASE_ID      (i),
      .MAX_PHRASE_LEN (MAX_PHRASE_LEN)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .scan    (scan),
      .chain_i (chain[i]),
      .chain_o (chain[i + 1])
    );
  end

  // Build the report. The chain end already includes the current byte.
  always_comb begin
    disabled_nxt = disabled_r;
    newly_nxt    = newly_r;
    flag_out_nxt = flag_out_r;
    index_nxt    = index_r;
    idx_sel      = IDX_NONE;
    if (in_xfer) begin
      if (in_chan.op == OP_DISABLE) begin
        disabled_nxt = 1'b1;
        newly_nxt    = 1'b0;
        flag_out_nxt = 1'b1;
        index_nxt    = idx_sel[PATTERN_IDX_W-1:0];
      end else if (in_chan.last) begin
        if (!disabled_r && chain[NUM_PHRASES].hit) begin
          disabled_nxt = 1'b1;
          newly_nxt    = 1'b1;
          idx_sel      = chain[NUM_PHRASES].idx;
        end else begin
          newly_nxt = 1'b0;
        end
        flag_out_nxt = disabled_nxt;
        index_nxt    = idx_sel[PATTERN_IDX_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disabled_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      disabled_r  <= disabled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Report payload; loaded only on a report transfer.
  always_ff @(posedge clk) begin
    newly_r    <= newly_nxt;
    flag_out_r <= flag_out_nxt;
    index_r    <= index_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.newly_disabled = newly_r;
  assign out_chan.disabled       = flag_out_r;
  assign out_chan.pattern_index  = index_r;

endmodule : error_text_pattern_disabler_core

`default_nettype wire
